FILE: rtl/kfc_pkg.sv
// Shared types and constants for the keyed FIFO with cancel.
// Used by every module in rtl/; depends on nothing.
`default_nettype none

package kfc_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int KEY_W  = 16;
    localparam int DATA_W = 32;
    localparam int TS_W   = 32;
    localparam int OCC_W  = 7;

    // front command queue, power of two so pointers wrap on their own
    localparam int FQ_DEPTH = 2;
    localparam int FQ_IDX_W = $clog2(FQ_DEPTH);
    localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_SEARCH = 2'd2,
        OP_CANCEL = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] payload;
        logic [TS_W-1:0]   timestamp;
    } cmd_word_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] payload;
        logic [TS_W-1:0]   arrival;
    } entry_t;

    typedef struct packed {
        logic capture;   // latch match / select vectors
        logic pop_head;  // select slot 0 instead of a key match
        logic push;      // append at the tail
        logic remove;    // drop the selected slot and close the gap
    } slot_ctl_t;

    typedef struct packed {
        logic             found;
        logic [CNT_W-1:0] count;
    } slot_stat_t;

    typedef struct packed {
        logic [1:0]      status;
        entry_t          entry;
        logic [TS_W-1:0] done_time;
        logic [OCC_W-1:0] occupancy;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/kfc_front.sv
// Front end: accepts command words, decodes the opcode and buffers them
// in a small queue for the back end. Depends on kfc_pkg.
`default_nettype none

module kfc_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [1:0]                  command,
    input  wire logic [kfc_pkg::KEY_W-1:0]   key,
    input  wire logic [kfc_pkg::DATA_W-1:0]  payload,
    input  wire logic [kfc_pkg::TS_W-1:0]    timestamp,
    output logic                             fq_valid,
    output kfc_pkg::cmd_word_t               fq_word,
    input  wire logic                        fq_take
);
    import kfc_pkg::*;

    cmd_word_t             word_reg [FQ_DEPTH];
    logic [FQ_IDX_W-1:0]   wr_ptr_reg;
    logic [FQ_IDX_W-1:0]   wr_ptr_next;
    logic [FQ_IDX_W-1:0]   rd_ptr_reg;
    logic [FQ_IDX_W-1:0]   rd_ptr_next;
    logic [FQ_CNT_W-1:0]   cnt_reg;
    logic [FQ_CNT_W-1:0]   cnt_next;
    logic                  wr_en;
    cmd_word_t             in_word;

    assign in_stall = (cnt_reg == FQ_CNT_W'(FQ_DEPTH));
    assign wr_en    = in_valid && !in_stall;
    assign fq_valid = (cnt_reg != '0);
    assign fq_word  = word_reg[rd_ptr_reg];

    always_comb
    begin
        in_word.op        = op_t'(command);
        in_word.key       = key;
        in_word.payload   = payload;
        in_word.timestamp = timestamp;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (fq_take)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (wr_en && !fq_take)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!wr_en && fq_take)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            word_reg[wr_ptr_reg] <= in_word;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/kfc_slots.sv
// Entry store as a row of cells: parallel key compare, first-match select,
// tail append and shift-down removal. Depends on kfc_pkg.
`default_nettype none

module kfc_slots (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire kfc_pkg::slot_ctl_t         ctl,
    input  wire logic [kfc_pkg::KEY_W-1:0]  match_key,
    input  wire kfc_pkg::entry_t            push_entry,
    output kfc_pkg::entry_t                 sel_entry,
    output kfc_pkg::slot_stat_t             stat
);
    import kfc_pkg::*;

    entry_t                  slot_reg [QUEUE_DEPTH];
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [QUEUE_DEPTH-1:0]  sel_reg;
    logic [QUEUE_DEPTH-1:0]  sel_next;
    logic [QUEUE_DEPTH-1:0]  tail_reg;
    logic [QUEUE_DEPTH-1:0]  tail_next;
    logic [QUEUE_DEPTH-1:0]  hit;
    logic [QUEUE_DEPTH-1:0]  upto;
    entry_t                  sel_or;

    // hit only among live slots; upto[i] = any hit at or below i
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            hit[i] = (slot_reg[i].key == match_key) && (CNT_W'(i) < count_reg);
        end
        upto = hit;
        for (int s = 0; s < IDX_W; s++)
        begin
            upto = upto | (upto << (1 << s));
        end
        if (ctl.pop_head)
        begin
            sel_next  = {{(QUEUE_DEPTH-1){1'b0}}, 1'b1};
            tail_next = '1;
        end
        else
        begin
            sel_next  = hit & ~(upto << 1);
            tail_next = upto;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            sel_reg  <= sel_next;
            tail_reg <= tail_next;
        end
    end

    // one-hot AND-OR read of the selected slot
    always_comb
    begin
        sel_or = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (sel_reg[i])
            begin
                sel_or = sel_or | slot_reg[i];
            end
        end
    end

    assign sel_entry   = sel_or;
    assign stat.found  = |sel_reg;
    assign stat.count  = count_reg;

    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_cell
        if (g < QUEUE_DEPTH - 1)
        begin : g_mid
            always_ff @(posedge clk)
            begin
                if (ctl.remove && tail_reg[g])
                begin
                    slot_reg[g] <= slot_reg[g+1];
                end
                else if (ctl.push && (count_reg == CNT_W'(g)))
                begin
                    slot_reg[g] <= push_entry;
                end
            end
        end
        else
        begin : g_last
            always_ff @(posedge clk)
            begin
                if (ctl.push && (count_reg == CNT_W'(g)))
                begin
                    slot_reg[g] <= push_entry;
                end
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctl.remove)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/kfc_back.sv
// Back end: two-step sequencer that runs one command against the slot
// store and fills the result register. Depends on kfc_pkg.
`default_nettype none

module kfc_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        fq_valid,
    input  wire kfc_pkg::cmd_word_t          fq_word,
    output logic                             fq_take,
    output kfc_pkg::slot_ctl_t               slot_ctl,
    output logic [kfc_pkg::KEY_W-1:0]        match_key,
    output kfc_pkg::entry_t                  push_entry,
    input  wire kfc_pkg::entry_t             sel_entry,
    input  wire kfc_pkg::slot_stat_t         slot_stat,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output kfc_pkg::result_t                 result
);
    import kfc_pkg::*;

    typedef enum logic [1:0] {
        BK_IDLE = 2'b01,
        BK_EXEC = 2'b10
    } bk_state_t;

    bk_state_t         state_reg;
    bk_state_t         state_next;
    cmd_word_t         cur_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           res_reg;
    result_t           res_next;
    logic              full;
    logic              empty;
    logic [CNT_W-1:0]  occ;

    assign match_key          = fq_word.key;
    assign push_entry.key     = cur_reg.key;
    assign push_entry.payload = cur_reg.payload;
    assign push_entry.arrival = cur_reg.timestamp;
    assign full               = (slot_stat.count == CNT_W'(QUEUE_DEPTH));
    assign empty              = (slot_stat.count == '0);
    assign out_valid          = out_valid_reg;
    assign result             = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        fq_take        = 1'b0;
        slot_ctl       = '0;
        occ            = slot_stat.count;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            BK_IDLE:
            begin
                // result register must be free by the time EXEC writes it
                if (fq_valid && (!out_valid_reg || !out_stall))
                begin
                    fq_take           = 1'b1;
                    slot_ctl.capture  = 1'b1;
                    slot_ctl.pop_head = (fq_word.op == OP_POP);
                    state_next        = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                res_next        = '0;
                res_next.status = ST_OK;
                case (cur_reg.op)
                    OP_PUSH:
                    begin
                        if (full)
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            slot_ctl.push  = 1'b1;
                            res_next.entry = push_entry;
                        end
                    end
                    OP_POP:
                    begin
                        if (empty)
                        begin
                            res_next.status = ST_EMPTY;
                        end
                        else
                        begin
                            slot_ctl.remove    = 1'b1;
                            res_next.entry     = sel_entry;
                            res_next.done_time = cur_reg.timestamp;
                        end
                    end
                    OP_SEARCH, OP_CANCEL:
                    begin
                        if (empty)
                        begin
                            res_next.status = ST_EMPTY;
                        end
                        else if (!slot_stat.found)
                        begin
                            res_next.status = ST_NOTFOUND;
                        end
                        else
                        begin
                            res_next.entry  = sel_entry;
                            slot_ctl.remove = (cur_reg.op == OP_CANCEL);
                        end
                    end
                    default:
                    begin
                        res_next.status = ST_OK;
                    end
                endcase
                if (slot_ctl.push)
                begin
                    occ = slot_stat.count + 1'b1;
                end
                else if (slot_ctl.remove)
                begin
                    occ = slot_stat.count - 1'b1;
                end
                res_next.occupancy = OCC_W'(occ);
                out_valid_next     = 1'b1;
                state_next         = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (fq_take)
        begin
            cur_reg <= fq_word;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/keyed_fifo_with_cancel_unit.sv
// Top level of the keyed FIFO with cancel: front queue, back sequencer
// and slot store. Depends on kfc_pkg, kfc_front, kfc_slots, kfc_back.
//
//   channel | handshake          | word
//   --------+--------------------+------------------------------------------
//   in      | in_valid/in_stall  | command, key, payload, timestamp
//   out     | out_valid/out_stall| status, entry_key, entry_payload,
//           |                    | entry_arrival, entry_done_time, occupancy
//
// In the back end each command runs as a compare and first-match select
// over all slots, then a read-out plus one shift-down or append. The back
// end takes a new command only after it has finished the last one;
// out_valid rises when the EXEC state writes the result register.
// Reset empties the queue at once; slot contents are not cleared.
// A stalled result holds the back end; the 2-deep front queue then fills and
// raises in_stall.
`default_nettype none

module keyed_fifo_with_cancel_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [1:0]                  command,
    input  wire logic [kfc_pkg::KEY_W-1:0]   key,
    input  wire logic [kfc_pkg::DATA_W-1:0]  payload,
    input  wire logic [kfc_pkg::TS_W-1:0]    timestamp,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [1:0]                       status,
    output logic [kfc_pkg::KEY_W-1:0]        entry_key,
    output logic [kfc_pkg::DATA_W-1:0]       entry_payload,
    output logic [kfc_pkg::TS_W-1:0]         entry_arrival,
    output logic [kfc_pkg::TS_W-1:0]         entry_done_time,
    output logic [kfc_pkg::OCC_W-1:0]        occupancy
);
    import kfc_pkg::*;

    logic              fq_valid;
    cmd_word_t         fq_word;
    logic              fq_take;
    slot_ctl_t         slot_ctl;
    logic [KEY_W-1:0]  match_key;
    entry_t            push_entry;
    entry_t            sel_entry;
    slot_stat_t        slot_stat;
    result_t           result;

    kfc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .key       (key),
        .payload   (payload),
        .timestamp (timestamp),
        .fq_valid  (fq_valid),
        .fq_word   (fq_word),
        .fq_take   (fq_take)
    );

    kfc_slots u_slots (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (slot_ctl),
        .match_key  (match_key),
        .push_entry (push_entry),
        .sel_entry  (sel_entry),
        .stat       (slot_stat)
    );

    kfc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fq_valid   (fq_valid),
        .fq_word    (fq_word),
        .fq_take    (fq_take),
        .slot_ctl   (slot_ctl),
        .match_key  (match_key),
        .push_entry (push_entry),
        .sel_entry  (sel_entry),
        .slot_stat  (slot_stat),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result     (result)
    );

    assign status          = result.status;
    assign entry_key       = result.entry.key;
    assign entry_payload   = result.entry.payload;
    assign entry_arrival   = result.entry.arrival;
    assign entry_done_time = result.done_time;
    assign occupancy       = result.occupancy;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (occupancy <= OCC_W'(QUEUE_DEPTH)))
        else $error("occupancy above queue depth");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_FULL)) |-> (occupancy == OCC_W'(QUEUE_DEPTH)))
        else $error("full reported with free slots");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_EMPTY)) |-> (occupancy == '0))
        else $error("empty reported with entries held");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |->
        ((entry_key == '0) && (entry_payload == '0) && (entry_arrival == '0)
         && (entry_done_time == '0)))
        else $error("entry fields not cleared on failed command");

endmodule

`default_nettype wire
